### rtl/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Command codes, status codes, state encoding and fixed ids for the
// synchronisation point table.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

  localparam int unsigned OP_W     = 4;
  localparam int unsigned ID_PORT_W = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;

  // entries held for the display blanking events after reset
  localparam int unsigned VBLANK_ID_A = 26;
  localparam int unsigned VBLANK_ID_B = 27;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE  = 4'd0,
    OP_ALLOCATE = 4'd1,
    OP_FREE     = 4'd2,
    OP_IS_ALLOC = 4'd3,
    OP_EXPIRED  = 4'd4,
    OP_ADD_MAX  = 4'd5,
    OP_READ_MIN = 4'd6,
    OP_LOAD_MIN = 4'd7,
    OP_FENCE    = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BUSY         = 3'd1,
    ST_NOT_RESERVED = 3'd2,
    ST_FULL         = 3'd3,
    ST_RANGE        = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

`default_nettype wire

### rtl/stm_free_finder.sv
// ----------------------------------------------------------------------------
// stm_free_finder
// Two-stage lowest-free-entry search: per-group summaries are registered,
// then the first group with a free entry is picked.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_free_finder #(
  parameter int unsigned ENTRY_COUNT = 192
) (
  input  wire logic                           clk,
  input  wire logic                           capture,
  input  wire logic [ENTRY_COUNT-1:0]         free_map,
  output logic                                found,
  output logic [$clog2(ENTRY_COUNT)-1:0]      found_id
);
  import stm_pkg::*;

  localparam int unsigned ID_W   = $clog2(ENTRY_COUNT);
  localparam int unsigned GRP_SZ = 16;
  localparam int unsigned LOW_W  = 4;
  localparam int unsigned NGRP   = (ENTRY_COUNT + GRP_SZ - 1) / GRP_SZ;
  localparam int unsigned GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned PAD_N  = NGRP * GRP_SZ;

  logic [PAD_N-1:0]     free_pad;
  logic [NGRP-1:0]      grp_any_next;
  logic [LOW_W-1:0]     grp_low_next [NGRP];
  logic [NGRP-1:0]      grp_any;
  logic [LOW_W-1:0]     grp_low [NGRP];
  logic [GRP_W-1:0]     sel_grp;

  assign free_pad = PAD_N'(free_map);

  // stage one: per group, any free and lowest free position
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_next[g] = |free_pad[g*GRP_SZ +: GRP_SZ];
      grp_low_next[g] = '0;
      for (int j = GRP_SZ - 1; j >= 0; j--) begin
        if (free_pad[g*GRP_SZ + j]) begin
          grp_low_next[g] = LOW_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      grp_any <= grp_any_next;
      for (int g = 0; g < NGRP; g++) begin
        grp_low[g] <= grp_low_next[g];
      end
    end
  end

  // stage two: first group that has room
  always_comb begin
    sel_grp = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sel_grp = GRP_W'(g);
      end
    end
  end

  assign found    = |grp_any;
  assign found_id = ID_W'({sel_grp, grp_low[sel_grp]});

endmodule

`default_nettype wire

### rtl/syncpoint_table_manager_unit.sv
// ----------------------------------------------------------------------------
// syncpoint_table_manager_unit
// Table of synchronisation points: reserve, allocate, free, query and
// counter commands, one result item per command item.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: in_valid / in_stall with opcode, entry_id,
//   external_managed and operand_value. Result channel: out_valid /
//   out_stall with result_id, result_value, result_flag and status.
//   Every command gives exactly one result item.
//   Timing: an item is taken in IDLE, which registers the counter
//   memory word, the command and the free-entry summaries; in EXEC the
//   block decides, writes back and loads the output register. A new
//   item is taken only once the previous one has left EXEC.
//   The block takes a new item while the previous result still sits in
//   the output register; it only holds in EXEC if that register is still
//   full and stalled when the next result is ready.
//   Reset (rst, synchronous): entries 26 and 27 are reserved and
//   externally managed, all others free; counters read as zero until
//   first written (per-entry valid bits, no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module syncpoint_table_manager_unit #(
  parameter int unsigned ENTRY_COUNT = 192
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [stm_pkg::OP_W-1:0]        opcode,
  input  wire logic [stm_pkg::ID_PORT_W-1:0]   entry_id,
  input  wire logic                            external_managed,
  input  wire logic [stm_pkg::VAL_W-1:0]       operand_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [stm_pkg::ID_PORT_W-1:0]        result_id,
  output logic [stm_pkg::VAL_W-1:0]            result_value,
  output logic                                 result_flag,
  output logic [stm_pkg::STATUS_W-1:0]         status
);
  import stm_pkg::*;

  localparam int unsigned ID_W  = $clog2(ENTRY_COUNT);
  localparam int unsigned CTR_W = 2 * VAL_W;

  // blanking entries held and externally managed out of reset
  localparam logic [ENTRY_COUNT-1:0] BLANK_MAP =
    (ENTRY_COUNT'(1) << VBLANK_ID_A) | (ENTRY_COUNT'(1) << VBLANK_ID_B);

  // control
  state_t state, state_next;
  logic   accept;
  logic   exec_done;

  // flag tables and counter memory ({max, min} per entry)
  logic [ENTRY_COUNT-1:0] reserved_bits;
  logic [ENTRY_COUNT-1:0] external_bits;
  logic [ENTRY_COUNT-1:0] ctr_vld;
  logic [CTR_W-1:0]       ctr_mem [ENTRY_COUNT];
  logic [CTR_W-1:0]       mem_q;

  // captured command
  logic [OP_W-1:0]  c_op;
  logic [ID_W-1:0]  c_idx;
  logic             c_range;
  logic             c_ext;
  logic [VAL_W-1:0] c_val;
  logic             c_res;
  logic             c_ctr_vld;

  logic             in_range;
  logic [ID_W-1:0]  in_idx;

  // free search
  logic [ENTRY_COUNT-1:0] free_map;
  logic                   alloc_found;
  logic [ID_W-1:0]        alloc_id;

  // execute stage
  logic [VAL_W-1:0]     cur_min, cur_max, new_max, dmin, dmax;
  logic                 res_we, res_val, ext_we, ctr_we;
  logic [ID_W-1:0]      wr_idx;
  logic [CTR_W-1:0]     ctr_wdata;
  logic [ID_PORT_W-1:0] r_id;
  logic [VAL_W-1:0]     r_val;
  logic                 r_flag;
  status_t              r_status;

  assign accept   = in_valid && !in_stall;
  assign in_idx   = entry_id[ID_W-1:0];
  assign in_range = ({1'b0, entry_id} < (ID_PORT_W + 1)'(ENTRY_COUNT));

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (exec_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result lands once the output register is free or being emptied
  always_comb begin
    in_stall  = 1'b1;
    exec_done = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_EXEC: exec_done = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  // ---- command capture and memory read ----
  always_ff @(posedge clk) begin
    if (accept) begin
      c_op      <= opcode;
      c_idx     <= in_idx;
      c_range   <= in_range;
      c_ext     <= external_managed;
      c_val     <= operand_value;
      c_res     <= in_range ? reserved_bits[in_idx] : 1'b0;
      c_ctr_vld <= in_range ? ctr_vld[in_idx] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_we && exec_done) begin
      ctr_mem[c_idx] <= ctr_wdata;
    end
    if (accept && in_range) begin
      mem_q <= ctr_mem[in_idx];
    end
  end

  // ---- lowest free id, entry 0 never handed out ----
  always_comb begin
    free_map    = ~reserved_bits;
    free_map[0] = 1'b0;
  end

  stm_free_finder #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_finder (
    .clk      (clk),
    .capture  (accept),
    .free_map (free_map),
    .found    (alloc_found),
    .found_id (alloc_id)
  );

  // ---- execute: decide, write back, form result ----
  assign cur_min = c_ctr_vld ? mem_q[VAL_W-1:0]     : '0;
  assign cur_max = c_ctr_vld ? mem_q[CTR_W-1:VAL_W] : '0;
  assign new_max = cur_max + c_val;
  assign dmin    = cur_min - c_val;
  assign dmax    = cur_max - c_val;

  always_comb begin
    res_we    = 1'b0;
    res_val   = 1'b0;
    ext_we    = 1'b0;
    ctr_we    = 1'b0;
    wr_idx    = c_idx;
    ctr_wdata = {cur_max, cur_min};
    r_id      = '0;
    r_val     = '0;
    r_flag    = 1'b0;
    r_status  = ST_OK;
    if (c_op == OP_ALLOCATE) begin
      if (alloc_found) begin
        res_we  = 1'b1;
        res_val = 1'b1;
        ext_we  = 1'b1;
        wr_idx  = alloc_id;
        r_id    = ID_PORT_W'(alloc_id);
      end else begin
        r_status = ST_FULL;
      end
    end else if (c_op > OP_FENCE) begin
      // unused codes: plain zero answer
      r_status = ST_OK;
    end else if (!c_range) begin
      r_status = ST_RANGE;
    end else if (c_op == OP_RESERVE) begin
      if (c_res) begin
        r_status = ST_BUSY;
      end else begin
        res_we  = 1'b1;
        res_val = 1'b1;
        ext_we  = 1'b1;
        r_id    = ID_PORT_W'(c_idx);
      end
    end else if (c_op == OP_IS_ALLOC) begin
      r_flag = c_res;
    end else if (!c_res) begin
      r_status = ST_NOT_RESERVED;
    end else begin
      case (c_op)
        OP_FREE: begin
          res_we = 1'b1;
        end
        OP_EXPIRED: begin
          // wrap-safe compare for external entries, window compare otherwise
          r_flag = external_bits[c_idx] ? !dmin[VAL_W-1] : (dmax >= dmin);
        end
        OP_ADD_MAX: begin
          ctr_we    = 1'b1;
          ctr_wdata = {new_max, cur_min};
          r_val     = new_max;
        end
        OP_READ_MIN: begin
          r_val = cur_min;
        end
        OP_LOAD_MIN: begin
          ctr_we    = 1'b1;
          ctr_wdata = {cur_max, c_val};
          r_val     = c_val;
        end
        default: begin
          r_id  = ID_PORT_W'(c_idx);
          r_val = cur_max;
        end
      endcase
    end
  end

  // flag tables and counter valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_bits <= BLANK_MAP;
      external_bits <= BLANK_MAP;
      ctr_vld       <= '0;
    end else if (state == S_EXEC && exec_done) begin
      if (res_we) reserved_bits[wr_idx] <= res_val;
      if (ext_we) external_bits[wr_idx] <= c_ext;
      if (ctr_we) ctr_vld[c_idx]        <= 1'b1;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EXEC && exec_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && exec_done) begin
      result_id    <= r_id;
      result_value <= r_val;
      result_flag  <= r_flag;
      status       <= r_status;
    end
  end

endmodule

`default_nettype wire

### bench/tb_syncpoint_table_manager_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_syncpoint_table_manager_unit
// Self-checking bench for the sync point table. It starts with a short table
// of directed commands, then runs phases of random commands that fill the
// table, work on a full table and drain it again. Every command item is
// predicted by a behavioural model of the table held here. Each result item
// is compared field by field with the oldest prediction. Both channels idle
// at random.
// ----------------------------------------------------------------------------

module tb_syncpoint_table_manager_unit;

  import stm_pkg::*;

  localparam int unsigned ENTRY_COUNT    = 192;
  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned PHASE_LEN      = 200;   // random commands per phase
  localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles with no item moving
  localparam int unsigned SETTLE_CYCLES  = 16;    // quiet time after last result
  localparam int unsigned HOLD_OFF_AT    = 1500;  // receiver cycle of the long stall
  localparam int unsigned HOLD_OFF_LEN   = 150;

  // opcodes with no meaning; the block must answer them with all zeros
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  // ids used by the directed rows, at port width
  localparam logic [ID_PORT_W-1:0] ID_BLANK_A  = ID_PORT_W'(VBLANK_ID_A);
  localparam logic [ID_PORT_W-1:0] ID_BLANK_B  = ID_PORT_W'(VBLANK_ID_B);
  localparam logic [ID_PORT_W-1:0] ID_PAST_END = ID_PORT_W'(ENTRY_COUNT);
  localparam logic [ID_PORT_W-1:0] ID_TOP      = ID_PORT_W'(ENTRY_COUNT - 1);

  // shape of the random traffic
  localparam int unsigned PHASE_BALANCED = 0;
  localparam int unsigned PHASE_FILL     = 1;
  localparam int unsigned PHASE_DRAIN    = 2;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_PORT_W-1:0] id;
    logic                 ext;
    logic [VAL_W-1:0]     operand;
  } command_t;

  typedef struct packed {
    logic [ID_PORT_W-1:0] id;
    logic [VAL_W-1:0]     value;
    logic                 flag;
    status_t              status;
  } answer_t;

  typedef struct {
    command_t cmd;
    bit       typed;   // 1: answer typed in below, 0: taken from the predictor
    answer_t  want;
  } directed_row_t;

  // --------------------------------------------------------------------------
  // Block ports. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic                 clk              = 1'b0;
  logic                 rst              = 1'b1;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      opcode           = '0;
  logic [ID_PORT_W-1:0] entry_id         = '0;
  logic                 external_managed = 1'b0;
  logic [VAL_W-1:0]     operand_value    = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic [ID_PORT_W-1:0] result_id;
  logic [VAL_W-1:0]     result_value;
  logic                 result_flag;
  logic [STATUS_W-1:0]  status;

  syncpoint_table_manager_unit #(
    .ENTRY_COUNT(ENTRY_COUNT)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .entry_id        (entry_id),
    .external_managed(external_managed),
    .operand_value   (operand_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_id       (result_id),
    .result_value    (result_value),
    .result_flag     (result_flag),
    .status          (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench copy of the table: flags and counters per entry.
  // --------------------------------------------------------------------------
  bit          slot_reserved [ENTRY_COUNT];
  bit          slot_external [ENTRY_COUNT];
  logic [31:0] slot_min      [ENTRY_COUNT];
  logic [31:0] slot_max      [ENTRY_COUNT];

  answer_t       pending_answers[$];   // predicted results, oldest first
  directed_row_t directed_rows[$];

  int unsigned commands_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned full_answers    = 0;
  int unsigned range_answers   = 0;
  int unsigned burst_left      = 0;
  int unsigned idle_cycles     = 0;

  function automatic void clear_table();
    int unsigned k;
    for (k = 0; k < ENTRY_COUNT; k++) begin
      slot_reserved[k] = 1'b0;
      slot_external[k] = 1'b0;
      slot_min[k]      = '0;
      slot_max[k]      = '0;
    end
    // the two blanking entries come out of reset held and externally managed
    slot_reserved[VBLANK_ID_A] = 1'b1;
    slot_reserved[VBLANK_ID_B] = 1'b1;
    slot_external[VBLANK_ID_A] = 1'b1;
    slot_external[VBLANK_ID_B] = 1'b1;
  endfunction

  // Carries out one command on the bench table and returns its answer.
  function automatic answer_t apply_command(command_t c);
    answer_t     a;
    int unsigned k;
    logic [31:0] dmin;
    logic [31:0] dmax;
    a = '{id: '0, value: '0, flag: 1'b0, status: ST_OK};
    if (c.op > OP_FENCE) return a;

    // allocate ignores the id and takes the lowest free entry above zero
    if (c.op == OP_ALLOCATE) begin
      for (k = 1; k < ENTRY_COUNT; k++) begin
        if (!slot_reserved[k]) begin
          slot_reserved[k] = 1'b1;
          slot_external[k] = c.ext;
          a.id = k[ID_PORT_W-1:0];
          return a;
        end
      end
      a.status = ST_FULL;
      return a;
    end

    if (c.id >= ENTRY_COUNT) begin
      a.status = ST_RANGE;
      return a;
    end

    if (c.op == OP_RESERVE) begin
      if (slot_reserved[c.id]) begin
        a.status = ST_BUSY;
      end else begin
        slot_reserved[c.id] = 1'b1;
        slot_external[c.id] = c.ext;
        a.id = c.id;
      end
      return a;
    end

    if (c.op == OP_IS_ALLOC) begin
      a.flag = slot_reserved[c.id];
      return a;
    end

    if (!slot_reserved[c.id]) begin
      a.status = ST_NOT_RESERVED;
      return a;
    end

    dmin = slot_min[c.id] - c.operand;
    dmax = slot_max[c.id] - c.operand;
    case (c.op)
      OP_FREE:     slot_reserved[c.id] = 1'b0;   // external flag and counters stay
      // external entries: wrap-safe signed compare; others: unsigned window
      OP_EXPIRED:  a.flag = slot_external[c.id] ? ~dmin[31] : (dmax >= dmin);
      OP_ADD_MAX: begin
        slot_max[c.id] = slot_max[c.id] + c.operand;
        a.value = slot_max[c.id];
      end
      OP_READ_MIN: a.value = slot_min[c.id];
      OP_LOAD_MIN: begin
        slot_min[c.id] = c.operand;
        a.value = c.operand;
      end
      default: begin
        a.id    = c.id;
        a.value = slot_max[c.id];
      end
    endcase
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Random command generation
  // --------------------------------------------------------------------------

  // A random entry that is currently held, so most commands get past the
  // not-reserved check.
  function automatic logic [ID_PORT_W-1:0] pick_held_id();
    int unsigned start;
    int unsigned k;
    int unsigned idx;
    start = $urandom_range(0, ENTRY_COUNT - 1);
    for (k = 0; k < ENTRY_COUNT; k++) begin
      idx = (start + k) % ENTRY_COUNT;
      if (slot_reserved[idx]) return idx[ID_PORT_W-1:0];
    end
    return start[ID_PORT_W-1:0];
  endfunction

  // Operands cluster round the entry's counters so both outcomes of the
  // expiry test turn up, with wrap-round amounts and plain noise mixed in.
  function automatic logic [VAL_W-1:0] pick_operand(logic [OP_W-1:0] op,
                                                    logic [ID_PORT_W-1:0] id);
    logic [31:0] base;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    base = '0;
    if (id < ENTRY_COUNT) base = $urandom_range(0, 1) ? slot_min[id] : slot_max[id];
    case (op)
      OP_ADD_MAX: begin
        if (roll < 60) return $urandom_range(0, 64);
        if (roll < 75) return 32'hFFFF_FFFF - $urandom_range(0, 16);
        return $urandom();
      end
      OP_EXPIRED, OP_LOAD_MIN: begin
        if (roll < 55) return base + $urandom_range(0, 16) - 8;
        if (roll < 65) return base ^ 32'h8000_0000;
        if (roll < 70) return 32'h0;
        if (roll < 75) return 32'hFFFF_FFFF;
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic command_t make_command(int unsigned phase);
    command_t    c;
    int unsigned roll;
    roll  = $urandom_range(0, 99);
    c.ext = 1'($urandom_range(0, 1));
    if (roll < 3) begin
      c.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else begin
      case (phase)
        PHASE_FILL: begin
          if (roll < 75)      c.op = OP_ALLOCATE;
          else if (roll < 80) c.op = OP_RESERVE;
          else                c.op = OP_W'($urandom_range(OP_IS_ALLOC, OP_FENCE));
        end
        PHASE_DRAIN: begin
          if (roll < 50)      c.op = OP_FREE;
          else if (roll < 55) c.op = OP_ALLOCATE;
          else                c.op = OP_W'($urandom_range(OP_IS_ALLOC, OP_FENCE));
        end
        default: c.op = OP_W'($urandom_range(OP_RESERVE, OP_FENCE));
      endcase
    end
    // ids: some anywhere in the port range, some anywhere in the table,
    // the rest on held entries; reserve leans towards free ones
    roll = $urandom_range(0, 99);
    if (roll < 10)
      c.id = ID_PORT_W'($urandom_range(0, 255));
    else if (roll < ((c.op == OP_RESERVE) ? 50 : 30))
      c.id = ID_PORT_W'($urandom_range(0, ENTRY_COUNT - 1));
    else
      c.id = pick_held_id();
    c.operand = pick_operand(c.op, c.id);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one command item and holds it until taken, then either
  // carries on with the burst or drops valid for a random gap.
  // --------------------------------------------------------------------------
  task automatic drive_item(input command_t c, input bit typed, input answer_t want);
    answer_t     predicted;
    int unsigned gap;
    in_valid         <= 1'b1;
    opcode           <= c.op;
    entry_id         <= c.id;
    external_managed <= c.ext;
    operand_value    <= c.operand;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // taken at this edge: update the bench table in the same order as the block
    predicted = apply_command(c);
    pending_answers.push_back(typed ? want : predicted);
    commands_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      // now and then a long run with no gap at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 15);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [ID_PORT_W-1:0] id,
                         input logic ext, input logic [VAL_W-1:0] operand,
                         input bit typed, input logic [ID_PORT_W-1:0] want_id,
                         input logic [VAL_W-1:0] want_value, input logic want_flag,
                         input status_t want_status);
    directed_row_t row;
    row.cmd   = '{op: op, id: id, ext: ext, operand: operand};
    row.typed = typed;
    row.want  = '{id: want_id, value: want_value, flag: want_flag, status: want_status};
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    answer_t     no_answer;
    int unsigned n;
    int unsigned seg;
    no_answer = '{id: '0, value: '0, flag: 1'b0, status: ST_OK};
    clear_table();

    // Directed table. Rows with typed = 0 are left to the predictor.
    //      opcode        id           ext   operand        t  id      value  flag status
    add_row(OP_IS_ALLOC,  ID_BLANK_A,  1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b1, ST_OK);
    add_row(OP_RESERVE,   ID_BLANK_B,  1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0, ST_BUSY);
    // id zero may be reserved by name although allocate never hands it out
    add_row(OP_RESERVE,   8'd0,        1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_ALLOCATE,  8'd200,      1'b1, 32'd0,          1, 8'd1,   32'd0, 1'b0, ST_OK);
    add_row(OP_RESERVE,   8'd255,      1'b1, 32'hFFFF_FFFF,  1, 8'd0,   32'd0, 1'b0, ST_RANGE);
    add_row(OP_READ_MIN,  ID_PAST_END, 1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0, ST_RANGE);
    add_row(OP_FREE,      8'd5,        1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0,
            ST_NOT_RESERVED);
    add_row(OP_UNUSED_HI, 8'd255,      1'b1, 32'hFFFF_FFFF,  1, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_UNUSED_LO, 8'd1,        1'b0, 32'd7,          1, 8'd0,   32'd0, 1'b0, ST_OK);
    // max counter wraps modulo 2^32
    add_row(OP_ADD_MAX,   8'd1,        1'b0, 32'hFFFF_FFFF,  1, 8'd0,   32'hFFFF_FFFF, 1'b0,
            ST_OK);
    add_row(OP_ADD_MAX,   8'd1,        1'b0, 32'd2,          1, 8'd0,   32'd1, 1'b0, ST_OK);
    add_row(OP_LOAD_MIN,  8'd1,        1'b0, 32'h8000_0000,  1, 8'd0,   32'h8000_0000, 1'b0,
            ST_OK);
    add_row(OP_READ_MIN,  8'd1,        1'b0, 32'd0,          1, 8'd0,   32'h8000_0000, 1'b0,
            ST_OK);
    add_row(OP_EXPIRED,   8'd1,        1'b0, 32'd0,          0, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_EXPIRED,   ID_BLANK_A,  1'b0, 32'd0,          0, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_FENCE,     8'd1,        1'b0, 32'd0,          1, 8'd1,   32'd1, 1'b0, ST_OK);
    // top entry, internally managed: window compare on both sides
    add_row(OP_RESERVE,   ID_TOP,      1'b0, 32'd0,          1, ID_TOP, 32'd0, 1'b0, ST_OK);
    add_row(OP_ADD_MAX,   ID_TOP,      1'b0, 32'd100,        0, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_LOAD_MIN,  ID_TOP,      1'b0, 32'd50,         0, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_EXPIRED,   ID_TOP,      1'b0, 32'd75,         0, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_EXPIRED,   ID_TOP,      1'b0, 32'd200,        0, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_FREE,      ID_TOP,      1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_FENCE,     ID_TOP,      1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0,
            ST_NOT_RESERVED);
    add_row(OP_IS_ALLOC,  ID_TOP,      1'b0, 32'd0,          1, 8'd0,   32'd0, 1'b0, ST_OK);
    add_row(OP_ALLOCATE,  8'd0,        1'b0, 32'd0,          1, 8'd2,   32'd0, 1'b0, ST_OK);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      drive_item(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

    // Random part in phases: balanced, fill, fill past full, drain, ...
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      seg = (n / PHASE_LEN) % 4;
      drive_item(make_command((seg == 0) ? PHASE_BALANCED :
                              (seg == 3) ? PHASE_DRAIN : PHASE_FILL), 1'b0, no_answer);
    end
    in_valid <= 1'b0;

    // wait for every outstanding result, then a quiet spell for strays
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d commands (%0d directed, %0d random), %0d results checked,",
             commands_sent, directed_rows.size(), RANDOM_ITEMS, results_checked);
    $display("     %0d mismatches, %0d allocations refused on a full table,",
             mismatches, full_answers);
    $display("     %0d out-of-range ids, one %0d-cycle hold-off",
             range_answers, HOLD_OFF_LEN);
    if (mismatches == 0) begin
      $display("** syncpoint_table_manager_unit: PASSED **");
    end else begin
      $display("** syncpoint_table_manager_unit: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall pattern that changes over the run, plus one long
  // hold-off so the output register fills and the block stalls its input.
  // --------------------------------------------------------------------------
  int unsigned rx_cycle   = 0;
  int unsigned rx_pattern = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      rx_cycle   <= 0;
      rx_pattern <= 0;
      hold_left  <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 128 == 0) rx_pattern <= $urandom_range(0, 3);
      if (rx_cycle == HOLD_OFF_AT)
        hold_left <= HOLD_OFF_LEN;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;

      if (rx_cycle == HOLD_OFF_AT || hold_left > 1) begin
        out_stall <= 1'b1;
      end else begin
        case (rx_pattern)
          0:       out_stall <= 1'b0;                          // free running
          1:       out_stall <= ($urandom_range(0, 3) == 0);   // light
          2:       out_stall <= ($urandom_range(0, 9) < 6);    // heavy
          default: out_stall <= rx_cycle[2];                   // blocks set by rx_cycle bit 2
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: oldest prediction against each result item taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result item with no command outstanding: id %0d value %0h status %0d",
               result_id, result_value, status);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        results_checked++;
        if (want.status == ST_FULL)  full_answers++;
        if (want.status == ST_RANGE) range_answers++;
        if (result_id !== want.id) begin
          $error("result_id: expected %0d, got %0d", want.id, result_id);
          mismatches++;
        end
        if (result_value !== want.value) begin
          $error("result_value: expected %0h, got %0h", want.value, result_value);
          mismatches++;
        end
        if (result_flag !== want.flag) begin
          $error("result_flag: expected %0b, got %0b", want.flag, result_flag);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with nothing moving on either channel ends the run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_answers.size());
      $display("** syncpoint_table_manager_unit: FAILED **");
      $finish;
    end
  end

endmodule
